FILE: rtl/core/rge_pkg.sv
// ----------------------------------------------------------------------------
// rge_pkg
// Types and constants shared by the refinement gradient estimator.
// ----------------------------------------------------------------------------
package rge_pkg;

  localparam int unsigned MaxAxes     = 3;
  localparam int unsigned NumAxesDef  = 3;
  localparam int unsigned DivStages   = 24;   // quotient bits of first-derivative term
  localparam int unsigned Div2Bits    = 17;   // quotient bits of second-derivative term

  localparam logic [23:0] OutMax      = 24'hFF_FFFF;
  localparam logic [16:0] OneQ16      = 17'h1_0000;
  localparam logic [15:0] EpsReset    = 16'd3277;
  localparam logic [16:0] AlphaReset  = 17'd0;

  localparam int unsigned AddrW       = 3;
  localparam logic [AddrW-1:0] AddrEps   = 3'h0;
  localparam logic [AddrW-1:0] AddrAlpha = 3'h4;

  typedef struct packed {
    logic signed [31:0] center_value;
    logic signed [31:0] x_low_value;
    logic signed [31:0] x_high_value;
    logic signed [31:0] y_low_value;
    logic signed [31:0] y_high_value;
    logic signed [31:0] z_low_value;
    logic signed [31:0] z_high_value;
    logic        [5:0]  boundary_mask;
  } cell_t;

  typedef struct packed {
    logic [23:0] refine_measure;
    logic        zero_denominator;
  } result_t;

endpackage

FILE: rtl/core/refinement_gradient_estimator.sv
// ----------------------------------------------------------------------------
// refinement_gradient_estimator
// Lohner-style second-derivative refinement measure for one grid cell,
// pipelined with restoring divider stages.
// ----------------------------------------------------------------------------
// Takes one cell every clock cycle: busy never rises, so start may be high
// in every cycle. Each accepted cell yields exactly one result, shown on
// result_o with valid_o high for one cycle; results leave in input order and
// cannot be held off. The pipeline is the input register, the difference
// stage, the 24-stage restoring divider of the first-derivative term (one
// quotient bit per stage), then the sum, blend and saturation stages.
// Registers: eps_scale at byte address 0, first_derivative_weight at 4; write
// them only while no cell is in flight.
module refinement_gradient_estimator #(
  parameter int unsigned NUM_AXES = rge_pkg::NumAxesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  rge_pkg::cell_t               cell_i,
  output logic                         valid_o,
  output rge_pkg::result_t             result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rge_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned DS = rge_pkg::DivStages;

  // configuration
  logic [15:0] eps_q;
  logic [16:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= rge_pkg::EpsReset;
      alpha_q <= rge_pkg::AlphaReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == rge_pkg::AddrEps) eps_q <= pwdata[15:0];
      if (paddr == rge_pkg::AddrAlpha) alpha_q <= pwdata[16:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == rge_pkg::AddrEps) prdata = {16'd0, eps_q};
    if (paddr == rge_pkg::AddrAlpha) prdata = {15'd0, alpha_q};
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // stage 1: input register
  logic           v1_q;
  rge_pkg::cell_t c1_q;

  // stage 2: differences
  logic                      v2_q;
  logic [31:0]               qref2_q;
  logic [46:0]               epsq2_q;
  logic [34:0]               sumab2_q [NUM_AXES];
  logic [34:0]               n2_q     [NUM_AXES];
  logic [34:0]               m2_q     [NUM_AXES];

  // divider stages
  logic              vd_q  [DS+1];
  logic [67:0]       r2_q  [DS+1][NUM_AXES];
  logic [51:0]       d2_q  [DS+1][NUM_AXES];
  logic [16:0]       qt2_q [DS+1][NUM_AXES];
  logic [55:0]       r1_q  [DS+1][NUM_AXES];
  logic [31:0]       d1_q  [DS+1];
  logic [23:0]       qt1_q [DS+1][NUM_AXES];
  logic [2:0]        fl_q  [DS+1][NUM_AXES]; // {sat1, zero1, zero2}

  logic              vd_d  [DS+1];
  logic [67:0]       r2_d  [DS+1][NUM_AXES];
  logic [51:0]       d2_d  [DS+1][NUM_AXES];
  logic [16:0]       qt2_d [DS+1][NUM_AXES];
  logic [55:0]       r1_d  [DS+1][NUM_AXES];
  logic [31:0]       d1_d  [DS+1];
  logic [23:0]       qt1_d [DS+1][NUM_AXES];
  logic [2:0]        fl_d  [DS+1][NUM_AXES];

  // tail stages
  logic        vf1_q, vf2_q, vo_q;
  logic [25:0] sum1_q;
  logic [18:0] sum2_q;
  logic        flf1_q, flf2_q;
  logic [42:0] p1_q;
  logic [35:0] p2_q;
  rge_pkg::result_t res_q;

  // neighbours by axis
  logic signed [31:0] lo_w [rge_pkg::MaxAxes];
  logic signed [31:0] hi_w [rge_pkg::MaxAxes];
  assign lo_w[0] = c1_q.x_low_value;
  assign hi_w[0] = c1_q.x_high_value;
  assign lo_w[1] = c1_q.y_low_value;
  assign hi_w[1] = c1_q.y_high_value;
  assign lo_w[2] = c1_q.z_low_value;
  assign hi_w[2] = c1_q.z_high_value;

  logic [31:0] qref_w;
  logic [34:0] sumab_w [NUM_AXES];
  logic [34:0] n_w     [NUM_AXES];
  logic [34:0] m_w     [NUM_AXES];

  always_comb begin
    logic signed [33:0] cc, dp, dm, t;
    logic signed [34:0] df, sm;
    logic [33:0] adp, adm;
    cc     = 34'(c1_q.center_value);
    qref_w = cc < 0 ? 32'(-cc) : 32'(cc);
    for (int a = 0; a < NUM_AXES; a++) begin
      dp = 34'(hi_w[a]) - cc;
      dm = cc - 34'(lo_w[a]);
      if (c1_q.boundary_mask[2*a]) dm = dp;
      if (c1_q.boundary_mask[2*a+1]) dp = dm;
      t   = dp;
      adp = t < 0 ? 34'(-t) : 34'(t);
      t   = dm;
      adm = t < 0 ? 34'(-t) : 34'(t);
      df  = 35'(dp) - 35'(dm);
      sm  = 35'(dp) + 35'(dm);
      sumab_w[a] = 35'(adp) + 35'(adm);
      n_w[a]     = df < 0 ? 35'(-df) : 35'(df);
      m_w[a]     = sm < 0 ? 35'(-sm) : 35'(sm);
    end
  end

  // divider setup and steps
  always_comb begin
    logic [51:0] den2;
    logic [67:0] sh2;
    logic [55:0] sh1;
    sh2     = '0;
    vd_d[0] = v2_q;
    d1_d[0] = qref2_q;
    for (int a = 0; a < NUM_AXES; a++) begin
      den2          = {sumab2_q[a][35-1:0], 16'd0} + 52'(epsq2_q);
      d2_d[0][a]    = den2;
      r2_d[0][a]    = {1'b0, n2_q[a], 32'd0};
      r1_d[0][a]    = {5'd0, m2_q[a], 16'd0};
      qt2_d[0][a]   = '0;
      qt1_d[0][a]   = '0;
      fl_d[0][a][0] = den2 == 52'd0;
      fl_d[0][a][1] = qref2_q == 32'd0;
      fl_d[0][a][2] = 40'(m2_q[a]) >= {qref2_q, 8'd0};
    end
    for (int s = 0; s < DS; s++) begin
      vd_d[s+1] = vd_q[s];
      d1_d[s+1] = d1_q[s];
      for (int a = 0; a < NUM_AXES; a++) begin
        d2_d[s+1][a]  = d2_q[s][a];
        fl_d[s+1][a]  = fl_q[s][a];
        r1_d[s+1][a]  = r1_q[s][a];
        qt1_d[s+1][a] = qt1_q[s][a];
        r2_d[s+1][a]  = r2_q[s][a];
        qt2_d[s+1][a] = qt2_q[s][a];
        sh1 = 56'(d1_q[s]) << (DS-1-s);
        if (r1_q[s][a] >= sh1) begin
          r1_d[s+1][a] = r1_q[s][a] - sh1;
          qt1_d[s+1][a][DS-1-s] = 1'b1;
        end
        if (DS-1-s < rge_pkg::Div2Bits) begin
          sh2 = 68'(d2_q[s][a]) << (DS-1-s);
          if (r2_q[s][a] >= sh2) begin
            r2_d[s+1][a] = r2_q[s][a] - sh2;
            qt2_d[s+1][a][DS-1-s] = 1'b1;
          end
        end
      end
    end
  end

  // tail: sum of terms
  logic [25:0] sum1_w;
  logic [18:0] sum2_w;
  logic        fl_w;
  always_comb begin
    sum1_w = '0;
    sum2_w = '0;
    fl_w   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      fl_w = fl_w | (|fl_q[DS][a]);
      if (!fl_q[DS][a][0]) sum2_w = sum2_w + 19'(qt2_q[DS][a]);
      if (!fl_q[DS][a][1]) begin
        sum1_w = sum1_w + (fl_q[DS][a][2] ? 26'(rge_pkg::OutMax) : 26'(qt1_q[DS][a]));
      end
    end
  end

  logic [16:0] alpha_w;
  assign alpha_w = alpha_q > rge_pkg::OneQ16 ? rge_pkg::OneQ16 : alpha_q;

  logic [43:0] tot_w;
  logic [27:0] sh_w;
  assign tot_w = 44'(p1_q) + 44'(p2_q);
  assign sh_w  = tot_w[43:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      for (int s = 0; s <= DS; s++) vd_q[s] <= 1'b0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      v1_q  <= start;
      v2_q  <= v1_q;
      for (int s = 0; s <= DS; s++) vd_q[s] <= vd_d[s];
      vf1_q <= vd_q[DS];
      vf2_q <= vf1_q;
      vo_q  <= vf2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q    <= cell_i;
    qref2_q <= qref_w;
    epsq2_q <= 47'(eps_q) * 47'(qref_w);
    for (int a = 0; a < NUM_AXES; a++) begin
      sumab2_q[a] <= sumab_w[a];
      n2_q[a]     <= n_w[a];
      m2_q[a]     <= m_w[a];
    end
    for (int s = 0; s <= DS; s++) begin
      d1_q[s] <= d1_d[s];
      for (int a = 0; a < NUM_AXES; a++) begin
        r2_q[s][a]  <= r2_d[s][a];
        d2_q[s][a]  <= d2_d[s][a];
        qt2_q[s][a] <= qt2_d[s][a];
        r1_q[s][a]  <= r1_d[s][a];
        qt1_q[s][a] <= qt1_d[s][a];
        fl_q[s][a]  <= fl_d[s][a];
      end
    end
    sum1_q <= sum1_w;
    sum2_q <= sum2_w;
    flf1_q <= fl_w;
    p1_q   <= 43'(alpha_w) * 43'(sum1_q);
    p2_q   <= 36'(rge_pkg::OneQ16 - alpha_w) * 36'(sum2_q);
    flf2_q <= flf1_q;
    if (sh_w > 28'(rge_pkg::OutMax)) begin
      res_q.refine_measure   <= rge_pkg::OutMax;
      res_q.zero_denominator <= 1'b1;
    end else begin
      res_q.refine_measure   <= sh_w[23:0];
      res_q.zero_denominator <= flf2_q;
    end
  end

  assign valid_o  = vo_q;
  assign result_o = res_q;

endmodule
